### sv/dtc_pkg.sv
// shared types, widths and constants of the disk thresholded centroid unit
`timescale 1ns / 1ps
`default_nettype none

package dtc_pkg;

    // field and register widths
    localparam int PIX_W      = 16;
    localparam int FW_W       = 13;
    localparam int CXY_W      = 16;
    localparam int RADIUS_W   = 34;
    localparam int BG_W       = 16;

    // accumulator widths
    localparam int CNT_W      = 24;
    localparam int SUM_W      = 40;
    localparam int WSUM_W     = 52;
    localparam int PEAK_W     = 16;

    // centroid division
    localparam int QUOT_W     = 20;
    localparam int FRAC_BITS  = 8;
    localparam int NUM_W      = WSUM_W + FRAC_BITS + 1;
    localparam int REM_W      = NUM_W - QUOT_W;
    localparam int QCNT_W     = $clog2(QUOT_W);

    // configuration port
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;
    localparam int REG_LSB    = 3;

    // register reset values
    localparam logic [FW_W-1:0]     RST_FRAME_WIDTH = FW_W'(256);
    localparam logic [CXY_W-1:0]    RST_CENTER_X    = CXY_W'(2048);
    localparam logic [CXY_W-1:0]    RST_CENTER_Y    = CXY_W'(2048);
    localparam logic [RADIUS_W-1:0] RST_RADIUS_SQ   = RADIUS_W'(262144);
    localparam logic [BG_W-1:0]     RST_BACKGROUND  = BG_W'(0);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FRAME_WIDTH = 3'd0,
        REG_CENTER_X    = 3'd1,
        REG_CENTER_Y    = 3'd2,
        REG_RADIUS_SQ   = 3'd3,
        REG_BACKGROUND  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [FW_W-1:0]     frame_width;
        logic [CXY_W-1:0]    center_x_q4;
        logic [CXY_W-1:0]    center_y_q4;
        logic [RADIUS_W-1:0] radius_sq_q8;
        logic [BG_W-1:0]     background;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             end_of_frame;
    } t_in_item;

    typedef struct packed {
        logic              status;
        logic [QUOT_W-1:0] centroid_x;
        logic [QUOT_W-1:0] centroid_y;
        logic [PEAK_W-1:0] peak;
        logic [SUM_W-1:0]  flux;
    } t_out_item;

    // divider status towards the sequencer
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_res;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHECK,
        DV_STEP
    } t_div_state;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_W_X,
        ST_W_Y,
        ST_ACC,
        ST_FRAME_END,
        ST_DIV_X,
        ST_DIV_Y,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

### sv/dtc_regs.sv
// configuration register file behind the apb-style port
`timescale 1ns / 1ps
`default_nettype none

module dtc_regs
    import dtc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[REG_LSB +: REG_IDX_W]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= RST_FRAME_WIDTH;
            r_cfg.center_x_q4  <= RST_CENTER_X;
            r_cfg.center_y_q4  <= RST_CENTER_Y;
            r_cfg.radius_sq_q8 <= RST_RADIUS_SQ;
            r_cfg.background   <= RST_BACKGROUND;
        end else if (wr_en) begin
            case (idx)
                REG_FRAME_WIDTH: r_cfg.frame_width  <= pwdata[FW_W-1:0];
                REG_CENTER_X:    r_cfg.center_x_q4  <= pwdata[CXY_W-1:0];
                REG_CENTER_Y:    r_cfg.center_y_q4  <= pwdata[CXY_W-1:0];
                REG_RADIUS_SQ:   r_cfg.radius_sq_q8 <= pwdata[RADIUS_W-1:0];
                REG_BACKGROUND:  r_cfg.background   <= pwdata[BG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_FRAME_WIDTH: prdata = APB_DATA_W'(r_cfg.frame_width);
            REG_CENTER_X:    prdata = APB_DATA_W'(r_cfg.center_x_q4);
            REG_CENTER_Y:    prdata = APB_DATA_W'(r_cfg.center_y_q4);
            REG_RADIUS_SQ:   prdata = APB_DATA_W'(r_cfg.radius_sq_q8);
            REG_BACKGROUND:  prdata = APB_DATA_W'(r_cfg.background);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### sv/dtc_mul.sv
// shared multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none

module dtc_mul #(
    parameter int W = 16
) (
    input  wire logic           i_clk,
    input  wire logic [W-1:0]   i_a,
    input  wire logic [W-1:0]   i_b,
    output logic      [2*W-1:0] o_prod
);

    logic [2*W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

### sv/dtc_div.sv
// restoring divider for the centroid, one quotient bit a cycle, clamped
`timescale 1ns / 1ps
`default_nettype none

module dtc_div
    import dtc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [SUM_W-1:0] i_divisor,
    output t_div_res              o_res
);

    localparam logic [QCNT_W-1:0] LAST_CNT = QCNT_W'(QUOT_W - 1);

    t_div_state          r_state;
    t_div_state          n_state;
    logic [REM_W-1:0]    r_rem;
    logic [QUOT_W-1:0]   r_low;
    logic [QUOT_W-1:0]   r_quot;
    logic [QCNT_W-1:0]   r_cnt;
    logic                r_done;
    logic [REM_W-1:0]    cmp_a;
    logic [REM_W:0]      diff;
    logic                ge;
    logic                finish;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            DV_IDLE:  if (i_start) n_state = DV_CHECK;
            DV_CHECK: n_state = ge ? DV_IDLE : DV_STEP;
            DV_STEP:  if (r_cnt == LAST_CNT) n_state = DV_IDLE;
            default:  n_state = DV_IDLE;
        endcase
    end

    // shared compare and subtract
    always_comb begin
        if (r_state == DV_CHECK) begin
            cmp_a = r_rem;
        end else begin
            cmp_a = {r_rem[REM_W-2:0], r_low[QUOT_W-1]};
        end
        diff   = {1'b0, cmp_a} - (REM_W + 1)'(i_divisor);
        ge     = !diff[REM_W];
        finish = (r_state == DV_CHECK && ge) || (r_state == DV_STEP && r_cnt == LAST_CNT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= finish;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    r_rem <= i_num[NUM_W-1:QUOT_W];
                    r_low <= i_num[QUOT_W-1:0];
                    r_cnt <= '0;
                end
            end
            DV_CHECK: begin
                // quotient would not fit: clamp
                if (ge) r_quot <= '1;
            end
            DV_STEP: begin
                r_rem  <= ge ? diff[REM_W-1:0] : cmp_a;
                r_quot <= {r_quot[QUOT_W-2:0], ge};
                r_low  <= {r_low[QUOT_W-2:0], 1'b0};
                r_cnt  <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_res.busy = (r_state != DV_IDLE);
    assign o_res.done = r_done;
    assign o_res.quot = r_quot;

endmodule

`default_nettype wire

### sv/disk_thresholded_centroid_unit.sv
// top level of the disk thresholded centroid unit: sequencer and accumulators
//
// Pixels of a frame arrive in raster order on a valid/ready channel; the
// block counts column and row itself against frame_width and keeps every
// pixel that lies strictly inside the configured circle and exceeds the
// background. Each pixel passes the transfer, then four products on one
// shared multiplier (dx squared, dy squared, value times column, value
// times row) and an accumulate step, and no new pixel is taken before
// these are done. On the pixel flagged end_of_frame the block adds an
// empty-disk check and two centroid divisions on one restoring divider,
// one quotient bit a cycle, before the result
// goes to the output register. That register holds the result until it is
// taken, while the next frame's pixels are already transferred; a second
// frame end waits only if the previous result is still pending. Centroids are
// in 1/256 pixel, rounded to nearest and clamped to 20 bits. Configuration is
// written through the apb-style port at byte address 8*i and must only change
// while the block is idle. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module disk_thresholded_centroid_unit
    import dtc_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // pixel stream
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    // result stream
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data
);

    // offset width in 1/16 pixel, covering both column*16 and the centre
    localparam int DXW      = (COORD_BITS + 4 > CXY_W) ? COORD_BITS + 4 : CXY_W;
    localparam int PW       = 2 * DXW;
    localparam int DW       = PW + 1;
    localparam int RW       = (DW > RADIUS_W) ? DW : RADIUS_W;
    localparam int WCMP     = (COORD_BITS + 1 > FW_W) ? COORD_BITS + 1 : FW_W;
    localparam int PIX_USED = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;

    localparam logic [PIX_W:0]   PIX_ONE_SH = (PIX_W + 1)'(1) << PIX_USED;
    localparam logic [PIX_W-1:0] PIX_MASK   = PIX_W'(PIX_ONE_SH - 1'b1);
    localparam logic [WCMP-1:0]  COL_LIM    = WCMP'(1) << COORD_BITS;

    t_cfg cfg;

    dtc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer and frame state
    t_state                r_state;
    t_state                n_state;
    logic [COORD_BITS-1:0] r_column;
    logic [COORD_BITS-1:0] r_row;
    logic [CNT_W-1:0]      r_count;
    logic [SUM_W-1:0]      r_sum;
    logic [WSUM_W-1:0]     r_xsum;
    logic [WSUM_W-1:0]     r_ysum;
    logic [PEAK_W-1:0]     r_peak;
    logic                  r_out_valid;

    // per-pixel working registers
    logic [DXW-1:0]        r_dx;
    logic [DXW-1:0]        r_dy;
    logic [PIX_W-1:0]      r_val;
    logic                  r_pos;
    logic                  r_last;
    logic [COORD_BITS-1:0] r_col_s;
    logic [COORD_BITS-1:0] r_row_s;
    logic [DW-1:0]         r_dist;
    logic                  r_keep;

    // frame result staging
    logic                  r_status;
    logic [QUOT_W-1:0]     r_cx;
    logic [QUOT_W-1:0]     r_cy;
    t_out_item             r_out;

    // shared units
    logic [DXW-1:0]        mul_a;
    logic [DXW-1:0]        mul_b;
    logic [PW-1:0]         m_prod;
    logic                  div_start;
    logic [NUM_W-1:0]      div_num;
    t_div_res              div_res;

    dtc_mul #(
        .W (DXW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (m_prod)
    );

    dtc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_num     (div_num),
        .i_divisor (r_sum),
        .o_res     (div_res)
    );

    // raster position and pixel preparation
    logic [WCMP-1:0]   fw_ext;
    logic [WCMP-1:0]   eff_w;
    logic [WCMP-1:0]   col_inc;
    logic              col_wrap;
    logic [DXW-1:0]    col_q4;
    logic [DXW-1:0]    row_q4;
    logic [DXW-1:0]    cx_ext;
    logic [DXW-1:0]    cy_ext;
    logic [DXW-1:0]    dx;
    logic [DXW-1:0]    dy;
    logic [PIX_W-1:0]  pix;
    logic              pos;
    logic [PIX_W-1:0]  val;
    logic              in_accept;
    logic              empty;
    logic              keep;
    logic              out_load;
    logic [WSUM_W-1:0] num_ws;

    always_comb begin
        // zero width counts as one, anything wider than the counter wraps it
        fw_ext   = WCMP'(cfg.frame_width);
        if (fw_ext == '0) begin
            eff_w = WCMP'(1);
        end else if (fw_ext > COL_LIM) begin
            eff_w = COL_LIM;
        end else begin
            eff_w = fw_ext;
        end
        col_inc  = WCMP'(r_column) + WCMP'(1);
        col_wrap = (col_inc >= eff_w);

        col_q4 = DXW'({r_column, 4'b0000});
        row_q4 = DXW'({r_row, 4'b0000});
        cx_ext = DXW'(cfg.center_x_q4);
        cy_ext = DXW'(cfg.center_y_q4);
        dx     = (col_q4 >= cx_ext) ? col_q4 - cx_ext : cx_ext - col_q4;
        dy     = (row_q4 >= cy_ext) ? row_q4 - cy_ext : cy_ext - row_q4;

        pix = i_in_data.pixel_value & PIX_MASK;
        pos = (pix > cfg.background);
        val = pix - cfg.background;

        // strictly inside the disk and above the background
        keep  = (RW'(r_dist) < RW'(cfg.radius_sq_q8)) && r_pos;
        empty = (r_count == '0) || (r_sum == '0);
    end

    // saturating accumulator updates
    logic [CNT_W:0]    cnt_add;
    logic [SUM_W:0]    sum_add;
    logic [WSUM_W:0]   xs_add;
    logic [WSUM_W:0]   ys_add;
    logic [CNT_W-1:0]  n_count;
    logic [SUM_W-1:0]  n_sum;
    logic [WSUM_W-1:0] n_xsum;
    logic [WSUM_W-1:0] n_ysum;
    logic [PEAK_W-1:0] n_peak;

    always_comb begin
        cnt_add = {1'b0, r_count} + (CNT_W + 1)'(1);
        sum_add = {1'b0, r_sum} + (SUM_W + 1)'(r_val);
        xs_add  = {1'b0, r_xsum} + (WSUM_W + 1)'(m_prod);
        ys_add  = {1'b0, r_ysum} + (WSUM_W + 1)'(m_prod);
        n_count = cnt_add[CNT_W] ? '1 : cnt_add[CNT_W-1:0];
        n_sum   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        n_xsum  = xs_add[WSUM_W] ? '1 : xs_add[WSUM_W-1:0];
        n_ysum  = ys_add[WSUM_W] ? '1 : ys_add[WSUM_W-1:0];
        n_peak  = (PEAK_W'(r_val) > r_peak) ? PEAK_W'(r_val) : r_peak;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (i_in_valid) n_state = ST_SQ_X;
            ST_SQ_X:      n_state = ST_SQ_Y;
            ST_SQ_Y:      n_state = ST_W_X;
            ST_W_X:       n_state = ST_W_Y;
            ST_W_Y:       n_state = ST_ACC;
            ST_ACC:       n_state = r_last ? ST_FRAME_END : ST_IDLE;
            ST_FRAME_END: n_state = empty ? ST_OUT : ST_DIV_X;
            ST_DIV_X:     if (div_res.done) n_state = ST_DIV_Y;
            ST_DIV_Y:     if (div_res.done) n_state = ST_OUT;
            ST_OUT:       if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: multiplier operands, divider start, handshakes
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        num_ws    = r_ysum;
        case (r_state)
            ST_SQ_X: begin
                mul_a = r_dx;
                mul_b = r_dx;
            end
            ST_SQ_Y: begin
                mul_a = r_dy;
                mul_b = r_dy;
            end
            ST_W_X: begin
                mul_a = DXW'(r_val);
                mul_b = DXW'(r_col_s);
            end
            ST_W_Y: begin
                mul_a = DXW'(r_val);
                mul_b = DXW'(r_row_s);
            end
            ST_FRAME_END: begin
                num_ws    = r_xsum;
                div_start = !empty;
            end
            ST_DIV_X: begin
                div_start = div_res.done;
            end
            default: ;
        endcase
        // rounded to nearest: weighted sum * 256 plus half the flux
        div_num    = NUM_W'({num_ws, {FRAC_BITS{1'b0}}}) + NUM_W'(r_sum >> 1);
        in_accept  = (r_state == ST_IDLE) && i_in_valid;
        out_load   = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);
        o_in_ready = (r_state == ST_IDLE);
    end

    // control state and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_column    <= '0;
            r_row       <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_xsum      <= '0;
            r_ysum      <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (in_accept) begin
                if (i_in_data.end_of_frame) begin
                    r_column <= '0;
                    r_row    <= '0;
                end else if (col_wrap) begin
                    r_column <= '0;
                    r_row    <= r_row + 1'b1;
                end else begin
                    r_column <= r_column + 1'b1;
                end
            end

            // value times column is in the product register here
            if (r_state == ST_W_Y && keep) begin
                r_count <= n_count;
                r_sum   <= n_sum;
                r_xsum  <= n_xsum;
                r_peak  <= n_peak;
            end

            // value times row
            if (r_state == ST_ACC && r_keep) begin
                r_ysum <= n_ysum;
            end

            // result handed over: start the next frame afresh
            if (out_load) begin
                r_count <= '0;
                r_sum   <= '0;
                r_xsum  <= '0;
                r_ysum  <= '0;
                r_peak  <= '0;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_dx    <= dx;
            r_dy    <= dy;
            r_val   <= val;
            r_pos   <= pos;
            r_last  <= i_in_data.end_of_frame;
            r_col_s <= r_column;
            r_row_s <= r_row;
        end
        if (r_state == ST_SQ_Y) begin
            r_dist <= DW'(m_prod);
        end
        if (r_state == ST_W_X) begin
            r_dist <= r_dist + DW'(m_prod);
        end
        if (r_state == ST_W_Y) begin
            r_keep <= keep;
        end
        if (r_state == ST_FRAME_END) begin
            r_status <= empty;
            r_cx     <= '0;
            r_cy     <= '0;
        end
        if (r_state == ST_DIV_X && div_res.done) begin
            r_cx <= div_res.quot;
        end
        if (r_state == ST_DIV_Y && div_res.done) begin
            r_cy <= div_res.quot;
        end
        if (out_load) begin
            r_out.status     <= r_status;
            r_out.centroid_x <= r_status ? '0 : r_cx;
            r_out.centroid_y <= r_status ? '0 : r_cy;
            r_out.peak       <= r_status ? '0 : r_peak;
            r_out.flux       <= r_status ? '0 : r_sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // divider is only started when it is free
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_res.busy)
        else $error("divider started while busy");

    // every counted pixel adds at least one to the flux
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_sum != '0))
        else $error("pixel count without flux");

    // flux only moves in state ST_W_Y or when the frame is handed over
    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_W_Y && r_state != ST_OUT) |=> $stable(r_sum))
        else $error("flux changed outside accumulate step");

    // a new result only appears from the hand-over state
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("result register loaded outside hand-over");

endmodule

`default_nettype wire
